// ----- rtl/core/htsed_pkg.sv -----
// types, character codes and the entity name table for the tag stripper and entity decoder
package htsed_pkg;

  localparam int ENT_DEPTH  = 5;
  localparam int NAME_COUNT = 13;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_TAG    = 4'b0010,
    MODE_ENT    = 4'b0100,
    MODE_BAD    = 4'b1000
  } mode_t;

  typedef logic [0:ENT_DEPTH-1][7:0] ent_buf_t;

  // what one accepted input beat does
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    mode_t           mode_nxt;
    logic [2:0]      len_nxt;
    logic            wr_en;
  } dec_t;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  localparam ent_buf_t NAME_TXT [NAME_COUNT] = '{
    '{"a", "m", "p", 8'h00, 8'h00},
    '{"l", "t", 8'h00, 8'h00, 8'h00},
    '{"g", "t", 8'h00, 8'h00, 8'h00},
    '{"q", "u", "o", "t", 8'h00},
    '{"n", "b", "s", "p", 8'h00},
    '{"l", "r", "m", 8'h00, 8'h00},
    '{"r", "l", "m", 8'h00, 8'h00},
    '{"n", "d", "a", "s", "h"},
    '{"m", "d", "a", "s", "h"},
    '{"l", "s", "q", "u", "o"},
    '{"r", "s", "q", "u", "o"},
    '{"l", "d", "q", "u", "o"},
    '{"r", "d", "q", "u", "o"}
  };

  localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [15:0] NAME_CP [NAME_COUNT] = '{
    16'h0026, 16'h003C, 16'h003E, 16'h0022, 16'h0020, 16'h200E, 16'h200F,
    16'h2013, 16'h2014, 16'h2018, 16'h2019, 16'h201C, 16'h201D
  };

endpackage

// ----- rtl/core/htsed_decode.sv -----
// combinational decode of one input byte against the parser state
module htsed_decode (
  input  logic [7:0]              text_byte,
  input  logic                    end_of_text,
  input  htsed_pkg::mode_t        mode,
  input  logic [2:0]              ent_len,
  input  htsed_pkg::ent_buf_t     ent_chars,
  output htsed_pkg::dec_t         dec
);

  logic            is_term;
  logic [1:0]      fin_cnt;
  logic [2:0][7:0] fin_bytes;

  assign is_term = (text_byte == htsed_pkg::CH_SEMI) || (text_byte == htsed_pkg::CH_SPACE);

  // digit of base 10 or 16, msb flags a valid digit
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (hex && c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (hex && c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  // entity finish: & + byte if empty, else name table, then number, else '?'
  always_comb begin
    logic            hit;
    logic            m;
    logic [15:0]     cp;
    logic            hex;
    logic [2:0]      start;
    logic            ok;
    logic [15:0]     val;
    logic [4:0]      d;
    hit       = 1'b0;
    cp        = 16'd0;
    hex       = 1'b0;
    start     = 3'd1;
    ok        = 1'b0;
    val       = 16'd0;
    d         = 5'd0;
    fin_cnt   = 2'd1;
    fin_bytes = {8'h00, 8'h00, htsed_pkg::CH_QMARK};

    for (int i = 0; i < htsed_pkg::NAME_COUNT; i++) begin
      m = (ent_len == htsed_pkg::NAME_LEN[i]);
      for (int k = 0; k < htsed_pkg::ENT_DEPTH; k++) begin
        if (3'(k) < htsed_pkg::NAME_LEN[i] && ent_chars[k] != htsed_pkg::NAME_TXT[i][k]) begin
          m = 1'b0;
        end
      end
      if (m && !hit) begin
        hit = 1'b1;
        cp  = htsed_pkg::NAME_CP[i];
      end
    end

    // numeric reference, at most four digits so the value stays below 16 bits
    hex   = (ent_len >= 3'd2) && (ent_chars[1] == htsed_pkg::CH_X);
    start = hex ? 3'd2 : 3'd1;
    ok    = (start < ent_len);
    for (int k = 1; k < htsed_pkg::ENT_DEPTH; k++) begin
      if (3'(k) >= start && 3'(k) < ent_len) begin
        d = digit_of(ent_chars[k], hex);
        if (!d[4]) begin
          ok = 1'b0;
        end
        val = hex ? {val[11:0], d[3:0]} : 16'(val * 16'd10 + {12'd0, d[3:0]});
      end
    end

    if (!hit && ent_chars[0] == htsed_pkg::CH_HASH && ok && val != 16'd0) begin
      hit = 1'b1;
      cp  = val;
    end

    if (ent_len == 3'd0) begin
      fin_cnt   = 2'd2;
      fin_bytes = {8'h00, text_byte, htsed_pkg::CH_AMP};
    end else if (hit) begin
      if (cp < 16'h0080) begin
        fin_cnt   = 2'd1;
        fin_bytes = {8'h00, 8'h00, cp[7:0]};
      end else if (cp < 16'h0800) begin
        fin_cnt   = 2'd2;
        fin_bytes = {8'h00, {2'b10, cp[5:0]}, {3'b110, cp[10:6]}};
      end else begin
        fin_cnt   = 2'd3;
        fin_bytes = {{2'b10, cp[5:0]}, {2'b10, cp[11:6]}, {4'b1110, cp[15:12]}};
      end
    end
  end

  always_comb begin
    dec          = '0;
    dec.mode_nxt = mode;
    dec.len_nxt  = ent_len;
    case (mode)
      htsed_pkg::MODE_TAG: begin
        if (text_byte == htsed_pkg::CH_GT) begin
          dec.mode_nxt = htsed_pkg::MODE_NORMAL;
        end
      end
      htsed_pkg::MODE_BAD: begin
        if (is_term) begin
          dec.cnt      = 2'd1;
          dec.bytes    = {8'h00, 8'h00, htsed_pkg::CH_QMARK};
          dec.mode_nxt = htsed_pkg::MODE_NORMAL;
        end
      end
      htsed_pkg::MODE_ENT: begin
        if (is_term) begin
          dec.cnt      = fin_cnt;
          dec.bytes    = fin_bytes;
          dec.mode_nxt = htsed_pkg::MODE_NORMAL;
        end else if (ent_len >= 3'(htsed_pkg::ENT_DEPTH)) begin
          dec.mode_nxt = htsed_pkg::MODE_BAD;
        end else begin
          dec.wr_en   = 1'b1;
          dec.len_nxt = ent_len + 3'd1;
        end
      end
      default: begin
        if (text_byte == htsed_pkg::CH_LT) begin
          dec.mode_nxt = htsed_pkg::MODE_TAG;
        end else if (text_byte == htsed_pkg::CH_AMP) begin
          dec.mode_nxt = htsed_pkg::MODE_ENT;
          dec.len_nxt  = 3'd0;
        end else begin
          dec.cnt   = 2'd1;
          dec.bytes = {8'h00, 8'h00, text_byte};
        end
      end
    endcase
    // open tag or entity is dropped at end of text
    if (end_of_text) begin
      dec.mode_nxt = htsed_pkg::MODE_NORMAL;
      dec.len_nxt  = 3'd0;
    end
  end

endmodule

// ----- rtl/core/html_tag_strip_entity_decode_top.sv -----
// latency: a byte's first output beat is offered the cycle after the byte is accepted
// throughput: one input beat per cycle while each byte gives at most one output byte and
//   the output is not stalled; a byte that gives more output bytes (up to 3) holds the input
//   as the three-byte result register drains one beat per cycle while out_tready is high
// reset: synchronous active-low rst_n returns to normal text mode with the result
//   register empty; the entity character store is undefined until written
module html_tag_strip_entity_decode_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // last_of_run
);

  htsed_pkg::mode_t    mode_r;
  logic [2:0]          ent_len_r;
  htsed_pkg::ent_buf_t ent_chars_r;
  logic [2:0][7:0]     obuf_r;
  logic [1:0]          cnt_r;
  logic [1:0]          cnt_nxt;
  htsed_pkg::dec_t     dec;
  logic                in_acc;
  logic                out_acc;

  htsed_decode u_decode (
    .text_byte   (in_tdata[7:0]),
    .end_of_text (in_tlast),
    .mode        (mode_r),
    .ent_len     (ent_len_r),
    .ent_chars   (ent_chars_r),
    .dec         (dec)
  );

  // take a new beat when the result register is empty or drains this cycle
  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = obuf_r[0];
  assign out_tlast  = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = dec.cnt;
    end else if (out_acc) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= htsed_pkg::MODE_NORMAL;
      ent_len_r <= 3'd0;
      cnt_r     <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        mode_r    <= dec.mode_nxt;
        ent_len_r <= dec.len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      obuf_r <= dec.bytes;
    end else if (out_acc) begin
      obuf_r <= {8'h00, obuf_r[2], obuf_r[1]};
    end
    if (in_acc && dec.wr_en) begin
      ent_chars_r[ent_len_r] <= in_tdata[7:0];
    end
  end

endmodule

// ----- tb/tb_html_tag_strip_entity_decode_top.sv -----
// testbench for the html tag stripper and entity decoder: byte stream in, decoded utf-8 checked out
module tb_html_tag_strip_entity_decode_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_BYTES    = 70;
  localparam int MAX_REPORTS     = 10;
  localparam int STORE_DEPTH     = htsed_pkg::ENT_DEPTH;
  localparam int N_NAMES         = htsed_pkg::NAME_COUNT;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  html_tag_strip_entity_decode_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // decoder state as the testbench sees it
  htsed_pkg::mode_t dec_mode;
  logic [7:0]       ent_store [STORE_DEPTH];
  logic [2:0]       ent_len;
  logic [7:0]       step_bytes [$];
  out_beat_t        decoded_q [$];

  string name_txt [N_NAMES] = '{"amp", "lt", "gt", "quot", "nbsp", "lrm", "rlm",
                                "ndash", "mdash", "lsquo", "rsquo", "ldquo", "rdquo"};
  int unsigned name_cp [N_NAMES] = '{'h26, 'h3C, 'h3E, 'h22, 'h20, 'h200E, 'h200F,
                                     'h2013, 'h2014, 'h2018, 'h2019, 'h201C, 'h201D};
  string hex_chars = "0123456789abcdefABCDEF";

  int errors       = 0;
  int idle_cycles  = 0;
  int bytes_sent   = 0;
  bit steady       = 1'b0;
  bit hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void put_utf8(int unsigned cp);
    if (cp < 'h80) begin
      step_bytes.push_back(8'(cp));
    end else if (cp < 'h800) begin
      step_bytes.push_back(8'(8'hC0 | (cp >> 6)));
      step_bytes.push_back(8'(8'h80 | (cp & 'h3F)));
    end else begin
      step_bytes.push_back(8'(8'hE0 | ((cp >> 12) & 'hF)));
      step_bytes.push_back(8'(8'h80 | ((cp >> 6) & 'h3F)));
      step_bytes.push_back(8'(8'h80 | (cp & 'h3F)));
    end
  endfunction

  function automatic int digit_of(logic [7:0] c, bit hex);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (hex && c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (hex && c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // entity closed by a semicolon or space
  function automatic void close_entity(logic [7:0] term);
    int unsigned val;
    int          pos;
    int          d;
    bit          ok;
    bit          hit;
    bit          hex;
    if (ent_len == 0) begin
      step_bytes.push_back(htsed_pkg::CH_AMP);
      step_bytes.push_back(term);
      return;
    end
    for (int i = 0; i < N_NAMES; i++) begin
      if (name_txt[i].len() == ent_len) begin
        hit = 1'b1;
        for (int k = 0; k < ent_len; k++)
          if (name_txt[i][k] != ent_store[k]) hit = 1'b0;
        if (hit) begin
          put_utf8(name_cp[i]);
          return;
        end
      end
    end
    if (ent_store[0] == htsed_pkg::CH_HASH) begin
      pos = 1;
      hex = 1'b0;
      val = 0;
      if (pos < ent_len && ent_store[1] == htsed_pkg::CH_X) begin
        hex = 1'b1;
        pos = 2;
      end
      ok = pos < ent_len;
      for (; pos < ent_len; pos++) begin
        d = digit_of(ent_store[pos], hex);
        if (d < 0) begin
          ok = 1'b0;
          break;
        end
        val = val * (hex ? 16 : 10) + d;
      end
      if (ok && val != 0) put_utf8(val);
      else step_bytes.push_back(htsed_pkg::CH_QMARK);
      return;
    end
    step_bytes.push_back(htsed_pkg::CH_QMARK);
  endfunction

  function automatic void decode_byte(logic [7:0] c, logic eot);
    out_beat_t b;
    step_bytes.delete();
    case (dec_mode)
      htsed_pkg::MODE_TAG: begin
        if (c == htsed_pkg::CH_GT) dec_mode = htsed_pkg::MODE_NORMAL;
      end
      htsed_pkg::MODE_BAD: begin
        if (c == htsed_pkg::CH_SEMI || c == htsed_pkg::CH_SPACE) begin
          step_bytes.push_back(htsed_pkg::CH_QMARK);
          dec_mode = htsed_pkg::MODE_NORMAL;
        end
      end
      htsed_pkg::MODE_ENT: begin
        if (c == htsed_pkg::CH_SEMI || c == htsed_pkg::CH_SPACE) begin
          close_entity(c);
          dec_mode = htsed_pkg::MODE_NORMAL;
        end else if (ent_len >= STORE_DEPTH) begin
          dec_mode = htsed_pkg::MODE_BAD;
        end else begin
          ent_store[ent_len] = c;
          ent_len++;
        end
      end
      default: begin
        if (c == htsed_pkg::CH_LT) begin
          dec_mode = htsed_pkg::MODE_TAG;
        end else if (c == htsed_pkg::CH_AMP) begin
          dec_mode = htsed_pkg::MODE_ENT;
          ent_len = 0;
        end else begin
          step_bytes.push_back(c);
        end
      end
    endcase
    if (eot) begin
      dec_mode = htsed_pkg::MODE_NORMAL;
      ent_len = 0;
    end
    foreach (step_bytes[i]) begin
      b.data = step_bytes[i];
      b.last = (i == step_bytes.size() - 1);
      decoded_q.push_back(b);
    end
  endfunction

  function automatic void log_mismatch(string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch: %s", what);
  endfunction

  // output side: each beat against the oldest expected one
  always @(posedge clk) begin : check_out
    out_beat_t exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        log_mismatch($sformatf("unexpected beat data=%h last=%b", out_tdata, out_tlast));
      end else begin
        exp_beat = decoded_q.pop_front();
        if (exp_beat.data !== out_tdata || exp_beat.last !== out_tlast)
          log_mismatch($sformatf("expected data=%h last=%b, got data=%h last=%b",
                                 exp_beat.data, exp_beat.last, out_tdata, out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL html_tag_strip_entity_decode_top");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin : rx_side
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!steady) stall = pick_gap();
      end
    end
  end

  // leaves in_tvalid high when no gap follows, so back-to-back beats stay valid
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    in_tdata  <= b;
    in_tlast  <= eot;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, eot);
    bytes_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eot_at_end && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_plain_and_tags();
    send_text("Hi>", 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("a<b &amp; c>d", 1'b0);
    // tag still open at end of text is dropped
    send_text("<xy", 1'b1);
    send_text("z", 1'b0);
    wait_drained();
  endtask

  task automatic test_named_entities();
    send_text("&amp;&gt &lrm;&mdash;&AMP;", 1'b0);
    wait_drained();
  endtask

  task automatic test_numeric_entities();
    send_text("&#65;&#xe9;&#xFFF;&#8212;", 1'b0);
    // no digits, signs, zero, 0x prefix, bad digits, upper case x
    send_text("&#x;&#;&#-5;&#0;&#0x1;&#xG1;&#X41;", 1'b0);
    wait_drained();
  endtask

  task automatic test_bare_and_overlong();
    send_text("&;& ", 1'b0);
    send_text("&abcdefgh;", 1'b0);
    send_text("&ab<&;", 1'b0);
    // entity still open at end of text is dropped
    send_text("&amp", 1'b1);
    send_text("x", 1'b0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 4; i++) send_text("&mdash;", 1'b0);
    // drain can only finish once the hold-off is over
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic send_fragment();
    logic [7:0] frag [$];
    logic [7:0] term;
    int         kind;
    int         n;
    int         eot_pos;
    kind = $urandom_range(0, 99);
    term = $urandom_range(0, 1) ? htsed_pkg::CH_SEMI : htsed_pkg::CH_SPACE;
    if (kind < 35) begin
      frag.push_back(htsed_pkg::CH_AMP);
      n = $urandom_range(0, N_NAMES - 1);
      for (int i = 0; i < name_txt[n].len(); i++) frag.push_back(name_txt[n][i]);
      frag.push_back(term);
    end else if (kind < 55) begin
      frag.push_back(htsed_pkg::CH_AMP);
      frag.push_back(htsed_pkg::CH_HASH);
      if ($urandom_range(0, 1)) begin
        frag.push_back(htsed_pkg::CH_X);
        repeat ($urandom_range(1, 3)) frag.push_back(hex_chars[$urandom_range(0, 21)]);
      end else begin
        repeat ($urandom_range(1, 4)) frag.push_back(hex_chars[$urandom_range(0, 9)]);
      end
      frag.push_back(term);
    end else if (kind < 65) begin
      frag.push_back(htsed_pkg::CH_LT);
      repeat ($urandom_range(0, 6)) begin
        n = $urandom_range(1, 255);
        frag.push_back(n == htsed_pkg::CH_GT ? 8'h41 : 8'(n));
      end
      frag.push_back(htsed_pkg::CH_GT);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 4)) frag.push_back(8'($urandom_range(1, 255)));
    end else begin
      // broken entities: overlong, signed numbers, unknown names, stray bytes inside
      frag.push_back(htsed_pkg::CH_AMP);
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(6, 8)) frag.push_back(8'("a" + $urandom_range(0, 25)));
        1: begin
          frag.push_back(htsed_pkg::CH_HASH);
          frag.push_back($urandom_range(0, 1) ? 8'h2D : 8'h2B);
          frag.push_back(hex_chars[$urandom_range(0, 9)]);
        end
        2: repeat ($urandom_range(1, 5)) frag.push_back(8'("a" + $urandom_range(0, 25)));
        default: repeat ($urandom_range(1, 7)) frag.push_back(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(0, 3) != 0) frag.push_back(term);
    end
    n = $urandom_range(0, 99);
    if (n < 10) eot_pos = frag.size() - 1;
    else if (n < 14) eot_pos = $urandom_range(0, frag.size() - 1);
    else eot_pos = -1;
    foreach (frag[i]) send_byte(frag[i], i == eot_pos);
  endtask

  task automatic test_random_text();
    int start_count;
    int frag_count;
    start_count = bytes_sent;
    frag_count = 0;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      steady = (frag_count >= 3 && frag_count < 7);
      send_fragment();
      frag_count++;
      // sender pause until the output side has caught up
      if (frag_count == 10) wait_drained();
    end
    steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    dec_mode  = htsed_pkg::MODE_NORMAL;
    ent_len   = 3'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_and_tags();
    test_named_entities();
    test_numeric_entities();
    test_bare_and_overlong();
    test_backpressure();
    test_random_text();
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("PASS html_tag_strip_entity_decode_top");
    else
      $display("FAIL html_tag_strip_entity_decode_top");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/htsed_pkg.sv
rtl/core/htsed_decode.sv
rtl/core/html_tag_strip_entity_decode_top.sv
tb/tb_html_tag_strip_entity_decode_top.sv
